// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hw/rtl/tpa_pkg.sv -----
package tpa_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int TABLE_DEPTH = 512;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int NUM_W       = SAMPLE_BITS + IDX_W;
    localparam int ROM_W       = 16;
    localparam int REG_W       = 14;
    localparam int DIST_W      = 15;
    localparam int FOLD_W      = 18;
    localparam int OUT_MAX     = 16383;

    localparam logic [0:0] ADDR_QUARTER = 1'b0;
    localparam logic [0:0] ADDR_HALF    = 1'b1;

    // Unambiguous range in mm at 20 MHz modulation, and the scale factors of the table.
    localparam real MM_PER_TURN  = 299792458.0 / 40000.0;
    localparam real TURN_PER_RAD = 1.0 / (8.0 * $atan(1.0));
    localparam real INV_DEPTH    = 1.0 / real'(TABLE_DEPTH);

    typedef logic [ROM_W-1:0] rom_t [TABLE_DEPTH];

    // One item after classification: dividend, divisor and octant flags.
    typedef struct packed {
        logic [NUM_W-1:0]       num;
        logic [SAMPLE_BITS-1:0] den;
        logic                   swapped;
        logic                   x_neg;
        logic                   y_neg;
        logic                   zero;
    } item_t;

    typedef struct packed {
        logic [NUM_W-1:0]       rem;
        logic [SAMPLE_BITS-1:0] den;
        logic [IDX_W-1:0]       quo;
        logic                   swapped;
        logic                   x_neg;
        logic                   y_neg;
        logic                   zero;
    } div_t;

    // Arctan table for one octant; range in mm at 20 MHz modulation.
    function automatic rom_t build_rom();
        rom_t r;
        real  v;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            v    = MM_PER_TURN * $atan(real'(i) * INV_DEPTH) * TURN_PER_RAD;
            r[i] = ROM_W'($rtoi($floor(v + 0.5)));
        end
        return r;
    endfunction

    localparam rom_t ATAN_ROM = build_rom();

endpackage

// ----- hw/rtl/tpa_front.sv -----
module tpa_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // [11:0] sample_y, [23:12] sample_x
    input  logic [23:0]             s_tdata,
    output logic                    f_valid,
    input  logic                    f_ready,
    output tpa_pkg::item_t          f_item
);
    import tpa_pkg::*;

    logic                   valid_reg;
    item_t                  item_reg;
    item_t                  item_next;
    logic [SAMPLE_BITS-1:0] y;
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] ay;
    logic [SAMPLE_BITS-1:0] ax;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;

    always_comb begin
        y  = s_tdata[SAMPLE_BITS-1:0];
        x  = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        ay = y[SAMPLE_BITS-1] ? (~y + 1'b1) : y;
        ax = x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
        item_next.swapped = (ax < ay);
        lo = item_next.swapped ? ax : ay;
        hi = item_next.swapped ? ay : ax;
        // lo * (TABLE_DEPTH - 1) as a shift and a subtract.
        item_next.num   = ({{IDX_W{1'b0}}, lo} << IDX_W) - {{IDX_W{1'b0}}, lo};
        item_next.den   = hi;
        item_next.x_neg = x[SAMPLE_BITS-1];
        item_next.y_neg = y[SAMPLE_BITS-1];
        item_next.zero  = (hi == '0);
    end

    assign s_tready = !valid_reg || f_ready;
    assign f_valid  = valid_reg;
    assign f_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_next;
        end
    end

endmodule

// ----- hw/rtl/tpa_queue.sv -----
`include "assert_macros.svh"

module tpa_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tpa_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_pop,
    output tpa_pkg::item_t out_item
);
    import tpa_pkg::*;

    item_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        push;
    logic        pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    `ASSERT_CLK(a_cnt_range, cnt_reg != 2'd3, "queue count out of range")
    `ASSERT_CLK(a_ptr_track, (cnt_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg), "queue pointers disagree with count")

endmodule

// ----- hw/rtl/tpa_back.sv -----
`include "assert_macros.svh"

module tpa_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  tpa_pkg::item_t             q_item,
    input  logic [tpa_pkg::REG_W-1:0]  quarter_mm,
    input  logic [tpa_pkg::REG_W-1:0]  half_mm,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [14:0] distance_mm, [15] zero pad
    output logic [15:0]                m_tdata
);
    import tpa_pkg::*;

    logic                     adv;
    logic [IDX_W:0]           dv_reg;
    div_t                     dp_reg [IDX_W+1];
    div_t                     dp_next [IDX_W+1];
    logic                     rv_reg;
    logic [ROM_W-1:0]         rom_reg;
    logic                     r_sw_reg;
    logic                     r_xn_reg;
    logic                     r_yn_reg;
    logic                     r_zero_reg;
    logic                     ov_reg;
    logic [DIST_W-1:0]        dist_reg;
    logic [DIST_W-1:0]        dist_next;
    logic signed [FOLD_W-1:0] f0;
    logic signed [FOLD_W-1:0] f1;
    logic signed [FOLD_W-1:0] f2;
    logic signed [FOLD_W-1:0] f3;

    // The whole back pipeline moves together unless the output is held.
    assign adv      = !ov_reg || m_tready;
    assign q_pop    = adv && q_valid;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {1'b0, dist_reg};

    always_comb begin
        dp_next[0].rem     = q_item.num;
        dp_next[0].den     = q_item.den;
        dp_next[0].quo     = '0;
        dp_next[0].swapped = q_item.swapped;
        dp_next[0].x_neg   = q_item.x_neg;
        dp_next[0].y_neg   = q_item.y_neg;
        dp_next[0].zero    = q_item.zero;
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar i = 0; i < IDX_W; i++) begin : g_div
        localparam int B = IDX_W - 1 - i;
        logic [NUM_W-1:0] sub;
        always_comb begin
            sub        = {{IDX_W{1'b0}}, dp_reg[i].den} << B;
            dp_next[i+1] = dp_reg[i];
            if (dp_reg[i].rem >= sub) begin
                dp_next[i+1].rem    = dp_reg[i].rem - sub;
                dp_next[i+1].quo[B] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= '0;
            rv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else if (adv) begin
            dv_reg <= {dv_reg[IDX_W-1:0], q_valid};
            rv_reg <= dv_reg[IDX_W];
            ov_reg <= rv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i <= IDX_W; i++) begin
                dp_reg[i] <= dp_next[i];
            end
            rom_reg    <= ATAN_ROM[dp_reg[IDX_W].quo];
            r_sw_reg   <= dp_reg[IDX_W].swapped;
            r_xn_reg   <= dp_reg[IDX_W].x_neg;
            r_yn_reg   <= dp_reg[IDX_W].y_neg;
            r_zero_reg <= dp_reg[IDX_W].zero;
            dist_reg   <= dist_next;
        end
    end

    always_comb begin
        f0 = signed'({{(FOLD_W-ROM_W){1'b0}}, rom_reg});
        f1 = r_sw_reg ? (signed'({{(FOLD_W-REG_W){1'b0}}, quarter_mm}) - f0) : f0;
        f2 = r_xn_reg ? (signed'({{(FOLD_W-REG_W){1'b0}}, half_mm}) - f1) : f1;
        f3 = r_yn_reg ? -f2 : f2;
        if (r_zero_reg) begin
            dist_next = '0;
        end else if (f3 > FOLD_W'(OUT_MAX)) begin
            dist_next = DIST_W'(OUT_MAX);
        end else if (f3 < -FOLD_W'(OUT_MAX)) begin
            dist_next = DIST_W'(-OUT_MAX);
        end else begin
            dist_next = f3[DIST_W-1:0];
        end
    end

    `ASSERT_CLK(a_div_rem, (dv_reg[IDX_W] && !dp_reg[IDX_W].zero) |-> (dp_reg[IDX_W].rem < {{IDX_W{1'b0}}, dp_reg[IDX_W].den}), "division remainder not below divisor")

endmodule

// ----- hw/rtl/tof_phase_atan2_lookup_top.sv -----
// Converts one signed (y, x) time-of-flight sample pair per beat into a signed phase
// distance in mm, using an octant-folded arctan table. A new beat is taken every cycle
// while the output side keeps up; after it is accepted into the front register, each
// beat passes through the two-entry queue, the input register and nine stages of the
// pipelined index divider (one quotient bit each), the table read and the folding
// output register. The quarter and half period registers sit at byte addresses 0 and 4;
// the user must write them only while idle; the block itself does not enforce it.
module tof_phase_atan2_lookup_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [11:0] sample_y, [23:12] sample_x
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [14:0] distance_mm, [15] zero pad
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tpa_pkg::*;

    logic             f_valid;
    logic             f_ready;
    item_t            f_item;
    logic             q_valid;
    logic             q_pop;
    item_t            q_item;
    logic [REG_W-1:0] quarter_reg;
    logic [REG_W-1:0] half_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[1:0] == 2'b00);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quarter_reg <= REG_W'(1873);
            half_reg    <= REG_W'(3747);
        end else if (wr_en) begin
            case (paddr[2])
                ADDR_QUARTER: quarter_reg <= pwdata[REG_W-1:0];
                ADDR_HALF:    half_reg    <= pwdata[REG_W-1:0];
                default:      quarter_reg <= quarter_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ADDR_QUARTER: prdata = {{(32-REG_W){1'b0}}, quarter_reg};
            ADDR_HALF:    prdata = {{(32-REG_W){1'b0}}, half_reg};
            default:      prdata = '0;
        endcase
    end

    tpa_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_item   (f_item)
    );

    tpa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_item  (q_item)
    );

    tpa_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item),
        .quarter_mm (quarter_reg),
        .half_mm    (half_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ----- tb/tof_phase_atan2_lookup_checker.sv -----
`timescale 1ns / 100ps

module tof_phase_atan2_lookup_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending_count
);
    import tpa_pkg::*;

    localparam int DEPTH = 512;

    logic [15:0]       octant_atan [DEPTH];
    logic [REG_W-1:0]  quarter_mm;
    logic [REG_W-1:0]  half_mm;
    logic [DIST_W-1:0] distance_queue [$];

    function automatic void fill_octant_atan();
        real scale;
        real v;
        scale = 299792458.0 / 40000.0;
        for (int i = 0; i < DEPTH; i++) begin
            v = scale * $atan(real'(i) / real'(DEPTH)) / (2.0 * 3.14159265358979323846);
            octant_atan[i] = 16'($rtoi($floor(v + 0.5)));
        end
    endfunction

    function automatic logic [DIST_W-1:0] phase_distance(logic signed [11:0] y,
                                                         logic signed [11:0] x);
        int ay;
        int ax;
        int lo;
        int hi;
        int idx;
        int res;
        bit swapped;
        ay = (y < 0) ? -int'(y) : int'(y);
        ax = (x < 0) ? -int'(x) : int'(x);
        swapped = ax < ay;
        lo = swapped ? ax : ay;
        hi = swapped ? ay : ax;
        if (hi == 0) return '0;
        idx = lo * (DEPTH - 1) / hi;
        res = octant_atan[idx];
        if (swapped) res = int'(quarter_mm) - res;
        if (x < 0) res = int'(half_mm) - res;
        if (y < 0) res = -res;
        if (res > OUT_MAX) res = OUT_MAX;
        if (res < -OUT_MAX) res = -OUT_MAX;
        return DIST_W'(res);
    endfunction

    initial begin
        fill_octant_atan();
    end

    assign pending_count = distance_queue.size();

    always @(posedge aclk) begin
        if (!aresetn) begin
            quarter_mm <= 14'd1873;
            half_mm <= 14'd3747;
            distance_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == ADDR_HALF) half_mm <= pwdata[REG_W-1:0];
                else quarter_mm <= pwdata[REG_W-1:0];
            end
            if (s_tvalid && s_tready)
                distance_queue.push_back(phase_distance(s_tdata[11:0], s_tdata[23:12]));
            if (m_tvalid && m_tready) begin
                if (distance_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected result beat, distance %0d",
                                 $signed(m_tdata[14:0]));
                end else begin
                    if (m_tdata !== {1'b0, distance_queue[0]}) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: distance expected %0d (pad 0) got %0d (pad %b)",
                                     $signed(distance_queue[0]), $signed(m_tdata[14:0]),
                                     m_tdata[15]);
                    end
                    void'(distance_queue.pop_front());
                end
            end
        end
    end

endmodule

// ----- tb/tb_tof_phase_atan2_lookup_top.sv -----
`timescale 1ns / 100ps

module tb_tof_phase_atan2_lookup_top;
    import tpa_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [11:0] sample_y, [23:12] sample_x
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [14:0] distance_mm, [15] zero pad
    logic [15:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending_count;

    int sample_count;
    int setting_count;
    bit steady_flow;
    bit hold_request;

    tof_phase_atan2_lookup_top u_top (.*);

    tof_phase_atan2_lookup_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("tb_tof_phase_atan2_lookup_top failed");
        $finish;
    end

    // Result side: random stalls, one long hold-off to back the pipeline up.
    initial begin
        m_tready = 1'b0;
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_request = 1'b0;
            end else begin
                m_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 22);
                @(posedge aclk);
            end
        end
    end

    task automatic send_sample(logic [11:0] y, logic [11:0] x);
        if (!steady_flow && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {x, y};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sample_count++;
    endtask

    task automatic write_period(logic [0:0] reg_sel, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        setting_count++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic random_burst(int n);
        logic [11:0] y;
        logic [11:0] x;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(4))
                0: begin
                    // Small magnitudes stress the index truncation.
                    y = 12'($signed($urandom_range(0, 16)) - 8);
                    x = 12'($signed($urandom_range(0, 16)) - 8);
                end
                1: begin
                    // Near the octant diagonals and axes.
                    y = 12'($urandom);
                    x = $urandom_range(1) ? y : -y;
                    if ($urandom_range(3) == 0) x = 12'(x + $urandom_range(2) - 1);
                    if ($urandom_range(5) == 0) x = 12'd0;
                end
                default: begin
                    y = 12'($urandom);
                    x = 12'($urandom);
                end
            endcase
            send_sample(y, x);
        end
    endtask

    initial begin
        logic [11:0] corners [6];
        corners = '{12'h800, 12'h801, 12'hfff, 12'h000, 12'h001, 12'h7ff};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_count = 0;
        setting_count = 0;
        steady_flow = 1'b0;
        hold_request = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: corner pairs whose indices share parity, reset periods.
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 4; j++)
                send_sample(corners[i], corners[(j * 2 + i) % 6]);
        send_sample(12'd0, 12'd0);
        drain();

        steady_flow = 1'b1;
        random_burst(300);
        steady_flow = 1'b0;
        hold_request = 1'b1;
        random_burst(300);
        drain();

        // Periods at both extremes; the top one drives the fold up to the clamp limit OUT_MAX.
        write_period(ADDR_QUARTER, 32'h0);
        write_period(ADDR_HALF, 32'h0);
        random_burst(250);
        drain();
        write_period(ADDR_QUARTER, 32'hffff_ffff);
        write_period(ADDR_HALF, 32'hffff_ffff);
        for (int i = 0; i < 6; i++) send_sample(corners[i], corners[5 - i]);
        random_burst(250);
        drain();
        for (int k = 0; k < 3; k++) begin
            write_period(ADDR_QUARTER, $urandom);
            write_period(ADDR_HALF, $urandom);
            random_burst(180);
            drain();
        end

        $display("Converted %0d sample pairs over %0d period register writes,",
                 sample_count, setting_count);
        $display("including corner samples, saturating periods and a long output stall.");
        if (fail_count == 0) begin
            $display("tb_tof_phase_atan2_lookup_top passed");
        end else begin
            $display("tb_tof_phase_atan2_lookup_top failed");
        end
        $finish;
    end

endmodule
